FILE: src/lru_lfu_ttl_result_cache_assert.svh
// Assertion macros shared by the result cache checker
`ifndef LRU_LFU_TTL_RESULT_CACHE_ASSERT_SVH
`define LRU_LFU_TTL_RESULT_CACHE_ASSERT_SVH

// same-cycle implication
`define LLTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LLTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lltc_pkg.sv
// Shared types and constants for the result cache
package lltc_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int OVERHEAD_DEF = 120;
    localparam int COST_W       = 15;
    localparam int DIM_W        = 13;
    localparam int K_W          = 16;
    localparam int MET_W        = 8;
    localparam int CNT_IN_W     = 11;
    localparam int ADDR_W       = 5;
    localparam int MEMUSED_W    = 20;

    localparam logic [DIM_W-1:0]    DIM_MAX   = 13'd4096;
    localparam logic [CNT_IN_W-1:0] COUNT_MAX = 11'd1024;
    localparam logic [31:0]         ALL32     = 32'hFFFF_FFFF;

    localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
    localparam logic [31:0] MAX_MEMORY_RST  = 32'd67108864;
    localparam logic [31:0] TTL_RST         = 32'd60;

    typedef enum logic [2:0] {
        ACT_LOOKUP   = 3'd0,
        ACT_STORE    = 3'd1,
        ACT_MUTATION = 3'd2,
        ACT_INVALL   = 3'd3,
        ACT_TICK     = 3'd4,
        ACT_CLEAR    = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_MISS   = 3'd0,
        ST_HIT    = 3'd1,
        ST_STORED = 3'd2,
        ST_DONE   = 3'd3,
        ST_REJECT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_POLICY   = 3'd0,
        REG_MAX_ENT  = 3'd1,
        REG_MAX_MEM  = 3'd2,
        REG_TTL      = 3'd3,
        REG_MUT_LIM  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        TOP_NONE   = 3'd0,
        TOP_DROP   = 3'd1,
        TOP_TOUCH  = 3'd2,
        TOP_INSERT = 3'd3,
        TOP_FLUSH  = 3'd4
    } tbl_op_t;

    typedef struct packed {
        logic [63:0]       key;
        logic [DIM_W-1:0]  dim;
        logic [K_W-1:0]    k;
        logic [MET_W-1:0]  metric;
        logic [31:0]       created;
        logic [COST_W-1:0] cost;
    } entry_t;

    typedef struct packed {
        tbl_op_t     op;
        entry_t      ent;
        logic [31:0] uses;
    } tbl_cmd_t;

    typedef struct packed {
        logic        policy;
        logic [4:0]  entry_limit;
        logic [31:0] max_memory;
        logic [31:0] ttl_limit;
        logic [31:0] mutation_limit;
    } cfg_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] a);
        sat_inc = (a == ALL32) ? a : a + 32'd1;
    endfunction

endpackage

FILE: src/lltc_cfg.sv
// APB configuration registers
module lltc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lltc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output lltc_pkg::cfg_t                 cfg
);

    lltc_pkg::cfg_t cfg_reg;
    logic [2:0]     ridx;

    assign ridx   = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cfg_reg.policy         <= 1'b0;
            cfg_reg.entry_limit    <= lltc_pkg::MAX_ENTRIES_RST;
            cfg_reg.max_memory     <= lltc_pkg::MAX_MEMORY_RST;
            cfg_reg.ttl_limit      <= lltc_pkg::TTL_RST;
            cfg_reg.mutation_limit <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                lltc_pkg::REG_POLICY:  cfg_reg.policy         <= pwdata[0];
                lltc_pkg::REG_MAX_ENT: cfg_reg.entry_limit    <= pwdata[4:0];
                lltc_pkg::REG_MAX_MEM: cfg_reg.max_memory     <= pwdata;
                lltc_pkg::REG_TTL:     cfg_reg.ttl_limit      <= pwdata;
                lltc_pkg::REG_MUT_LIM: cfg_reg.mutation_limit <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            lltc_pkg::REG_POLICY:  prdata = {31'd0, cfg_reg.policy};
            lltc_pkg::REG_MAX_ENT: prdata = {27'd0, cfg_reg.entry_limit};
            lltc_pkg::REG_MAX_MEM: prdata = cfg_reg.max_memory;
            lltc_pkg::REG_TTL:     prdata = cfg_reg.ttl_limit;
            lltc_pkg::REG_MUT_LIM: prdata = cfg_reg.mutation_limit;
            default:               prdata = '0;
        endcase
    end

endmodule

FILE: src/lltc_table.sv
// Slot table: entry memory, use counts, valid bits and recency ranks
module lltc_table #(
    parameter int ENTRIES = lltc_pkg::ENTRIES_DEF,
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lltc_pkg::tbl_cmd_t   cmd,
    input  logic [IDX_W-1:0]     cmd_idx,
    input  logic [IDX_W-1:0]     cmd_rank,
    input  logic [IDX_W-1:0]     rd_idx,
    output lltc_pkg::entry_t     rd_ent,
    output logic [31:0]          rd_uses,
    output logic [IDX_W-1:0]     rd_rank,
    output logic                 rd_valid,
    output logic                 free_have,
    output logic [IDX_W-1:0]     free_idx
);

    lltc_pkg::entry_t ent_mem [ENTRIES];
    logic [31:0]      uses_mem [ENTRIES];
    logic [IDX_W-1:0] rank_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    lltc_pkg::entry_t rd_ent_reg;
    logic [31:0]      rd_uses_reg;
    logic [IDX_W-1:0] rd_rank_reg;
    logic             rd_valid_reg;

    assign rd_ent   = rd_ent_reg;
    assign rd_uses  = rd_uses_reg;
    assign rd_rank  = rd_rank_reg;
    assign rd_valid = rd_valid_reg;

    always_ff @(posedge clk) begin
        if (cmd.op == lltc_pkg::TOP_INSERT)
        begin
            ent_mem[cmd_idx] <= cmd.ent;
        end
        if (cmd.op == lltc_pkg::TOP_INSERT || cmd.op == lltc_pkg::TOP_TOUCH)
        begin
            uses_mem[cmd_idx] <= cmd.uses;
        end
        rd_ent_reg   <= ent_mem[rd_idx];
        rd_uses_reg  <= uses_mem[rd_idx];
        rd_rank_reg  <= rank_reg[rd_idx];
        rd_valid_reg <= valid_reg[rd_idx];
    end

    // ranks shift around the dropped, touched or inserted entry; all in parallel
    always_ff @(posedge clk) begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            case (cmd.op)
                lltc_pkg::TOP_DROP:
                    if (valid_reg[j] && IDX_W'(j) != cmd_idx && rank_reg[j] > cmd_rank)
                        rank_reg[j] <= rank_reg[j] - 1'b1;
                lltc_pkg::TOP_TOUCH:
                    if (IDX_W'(j) == cmd_idx)
                        rank_reg[j] <= '0;
                    else if (valid_reg[j] && rank_reg[j] < cmd_rank)
                        rank_reg[j] <= rank_reg[j] + 1'b1;
                lltc_pkg::TOP_INSERT:
                    if (IDX_W'(j) == cmd_idx)
                        rank_reg[j] <= '0;
                    else if (valid_reg[j])
                        rank_reg[j] <= rank_reg[j] + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                lltc_pkg::TOP_DROP:   valid_reg[cmd_idx] <= 1'b0;
                lltc_pkg::TOP_INSERT: valid_reg[cmd_idx] <= 1'b1;
                lltc_pkg::TOP_FLUSH:  valid_reg <= '0;
                default: ;
            endcase
        end
    end

    // lowest free slot
    always_comb begin
        free_have = 1'b0;
        free_idx  = '0;
        for (int j = ENTRIES - 1; j >= 0; j--)
        begin
            if (!valid_reg[j])
            begin
                free_have = 1'b1;
                free_idx  = IDX_W'(j);
            end
        end
    end

endmodule

FILE: src/lru_lfu_ttl_result_cache.sv
// Query result cache: sequencer, slot scan unit and statistics
// Fully associative cache of ENTRIES slots, one request at a time. A lookup scans
// the slots through the table read port and then resolves, ending the scan early
// on a hit. A store goes through check, duplicate scan, resolve and insert, and
// each eviction adds check, victim scan and drop. Mutation, flush, tick,
// statistics and rejected requests give their result in the cycle after
// acceptance. All of it goes through the single registered read port of the
// slot table and the one compare unit on its output. A result is held on the
// output until taken; in_ready is high only while idle, so the next request is
// accepted in the cycle after the result is taken at the earliest.
module lru_lfu_ttl_result_cache #(
    parameter int ENTRIES        = lltc_pkg::ENTRIES_DEF,
    parameter int ENTRY_OVERHEAD = lltc_pkg::OVERHEAD_DEF,
    localparam int IDX_W = $clog2(ENTRIES),
    localparam int CNT_W = $clog2(ENTRIES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lltc_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        action,
    input  logic [63:0]                       query_key,
    input  logic [lltc_pkg::DIM_W-1:0]        vector_dimension,
    input  logic [lltc_pkg::K_W-1:0]          result_k,
    input  logic [lltc_pkg::MET_W-1:0]        metric,
    input  logic [lltc_pkg::CNT_IN_W-1:0]     result_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        status,
    output logic [IDX_W-1:0]                  slot,
    output logic [31:0]                       hit_count,
    output logic [31:0]                       miss_count,
    output logic [31:0]                       eviction_count,
    output logic [31:0]                       invalidation_count,
    output logic [CNT_W-1:0]                  entry_count,
    output logic [lltc_pkg::MEMUSED_W-1:0]    memory_used
);

    localparam int HB_W  = CNT_W + lltc_pkg::COST_W;
    localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CHECK   = 8'b0000_0010,
        S_VICTIM  = 8'b0000_0100,
        S_EVICT   = 8'b0000_1000,
        S_MATCH   = 8'b0001_0000,
        S_RESOLVE = 8'b0010_0000,
        S_INSERT  = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

    lltc_pkg::cfg_t cfg;

    state_t state_reg, state_next;
    logic is_store_reg, is_store_next;
    lltc_pkg::entry_t req_reg, req_next;
    lltc_pkg::status_t status_reg, status_next;
    logic [IDX_W-1:0] slot_reg, slot_next;

    logic [31:0] hits_reg, hits_next, miss_reg, miss_next;
    logic [31:0] evict_reg, evict_next, inval_reg, inval_next;
    logic [31:0] now_reg, now_next, mut_reg, mut_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [HB_W-1:0]  bytes_reg, bytes_next;

    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             data_v_reg;
    logic [IDX_W-1:0] data_idx_reg;
    logic             issue, scan_end;

    logic             sel_have_reg, sel_have_next;
    logic [IDX_W-1:0] sel_idx_reg, sel_idx_next;
    logic [IDX_W-1:0] sel_rank_reg, sel_rank_next;
    logic [31:0]      sel_uses_reg, sel_uses_next;
    logic [31:0]      sel_created_reg, sel_created_next;
    logic [lltc_pkg::COST_W-1:0] sel_cost_reg, sel_cost_next;

    lltc_pkg::tbl_cmd_t cmd;
    logic [IDX_W-1:0]   cmd_idx, cmd_rank;
    lltc_pkg::entry_t   rd_ent;
    logic [31:0]        rd_uses;
    logic [IDX_W-1:0]   rd_rank;
    logic               rd_valid;
    logic               free_have;
    logic [IDX_W-1:0]   free_idx;

    logic               hit_match, better;
    logic [LIM_W-1:0]   limit;
    logic               need_evict;
    logic [lltc_pkg::COST_W-1:0] new_cost;
    logic [32:0]        inval_sum;
    logic [31:0]        mut_inc;

    lltc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lltc_table #(.ENTRIES(ENTRIES)) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_idx   (cmd_idx),
        .cmd_rank  (cmd_rank),
        .rd_idx    (scan_cnt_reg[IDX_W-1:0]),
        .rd_ent    (rd_ent),
        .rd_uses   (rd_uses),
        .rd_rank   (rd_rank),
        .rd_valid  (rd_valid),
        .free_have (free_have),
        .free_idx  (free_idx)
    );

    assign in_ready           = (state_reg == S_IDLE);
    assign out_valid          = (state_reg == S_OUT);
    assign status             = status_reg;
    assign slot               = slot_reg;
    assign hit_count          = hits_reg;
    assign miss_count         = miss_reg;
    assign eviction_count     = evict_reg;
    assign invalidation_count = inval_reg;
    assign entry_count        = held_reg;
    assign memory_used        = lltc_pkg::MEMUSED_W'(bytes_reg);

    assign issue    = (state_reg == S_VICTIM || state_reg == S_MATCH) &&
                      (scan_cnt_reg != CNT_W'(ENTRIES));
    assign scan_end = (scan_cnt_reg == CNT_W'(ENTRIES)) && !data_v_reg;

    // compare unit on the table read port
    assign hit_match = rd_valid && rd_ent.key == req_reg.key && rd_ent.dim == req_reg.dim &&
                       rd_ent.k == req_reg.k && rd_ent.metric == req_reg.metric;
    always_comb begin
        if (!rd_valid)
            better = 1'b0;
        else if (!sel_have_reg)
            better = 1'b1;
        else if (!cfg.policy)
            better = rd_rank > sel_rank_reg;
        else
            better = (rd_uses < sel_uses_reg) ||
                     (rd_uses == sel_uses_reg && rd_rank > sel_rank_reg);
    end

    assign limit = (LIM_W'(cfg.entry_limit) > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES)
                                                               : LIM_W'(cfg.entry_limit);
    assign need_evict = (held_reg != '0) &&
                        ((LIM_W'(held_reg) >= limit) ||
                         (33'(bytes_reg) + 33'(req_reg.cost) > 33'(cfg.max_memory)));

    assign new_cost = lltc_pkg::COST_W'(ENTRY_OVERHEAD) +
                      (lltc_pkg::COST_W'(vector_dimension) << 2) +
                      (lltc_pkg::COST_W'(result_count) << 3) +
                      (lltc_pkg::COST_W'(result_count) << 2);
    assign inval_sum = 33'(inval_reg) + 33'(held_reg);
    assign mut_inc   = lltc_pkg::sat_inc(mut_reg);

    always_comb begin
        state_next       = state_reg;
        is_store_next    = is_store_reg;
        req_next         = req_reg;
        status_next      = status_reg;
        slot_next        = slot_reg;
        hits_next        = hits_reg;
        miss_next        = miss_reg;
        evict_next       = evict_reg;
        inval_next       = inval_reg;
        now_next         = now_reg;
        mut_next         = mut_reg;
        held_next        = held_reg;
        bytes_next       = bytes_reg;
        scan_cnt_next    = issue ? scan_cnt_reg + 1'b1 : scan_cnt_reg;
        sel_have_next    = sel_have_reg;
        sel_idx_next     = sel_idx_reg;
        sel_rank_next    = sel_rank_reg;
        sel_uses_next    = sel_uses_reg;
        sel_created_next = sel_created_reg;
        sel_cost_next    = sel_cost_reg;
        cmd.op           = lltc_pkg::TOP_NONE;
        cmd.ent          = req_reg;
        cmd.uses         = 32'd1;
        cmd_idx          = sel_idx_reg;
        cmd_rank         = sel_rank_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = S_OUT;
                    status_next   = lltc_pkg::ST_DONE;
                    slot_next     = '0;
                    req_next.key     = query_key;
                    req_next.dim     = vector_dimension;
                    req_next.k       = result_k;
                    req_next.metric  = metric;
                    req_next.created = now_reg;
                    req_next.cost    = new_cost;
                    scan_cnt_next = '0;
                    sel_have_next = 1'b0;
                    case (action)
                        lltc_pkg::ACT_LOOKUP:
                            if (vector_dimension == '0 || result_k == '0)
                                status_next = lltc_pkg::ST_REJECT;
                            else
                            begin
                                is_store_next = 1'b0;
                                state_next    = S_MATCH;
                            end
                        lltc_pkg::ACT_STORE:
                            if (vector_dimension == '0 || vector_dimension > lltc_pkg::DIM_MAX ||
                                result_count > lltc_pkg::COUNT_MAX)
                                status_next = lltc_pkg::ST_REJECT;
                            else
                            begin
                                is_store_next = 1'b1;
                                state_next    = S_CHECK;
                            end
                        lltc_pkg::ACT_MUTATION:
                        begin
                            mut_next = mut_inc;
                            if (cfg.mutation_limit != '0 && mut_inc >= cfg.mutation_limit)
                            begin
                                cmd.op     = lltc_pkg::TOP_FLUSH;
                                inval_next = inval_sum[32] ? lltc_pkg::ALL32 : inval_sum[31:0];
                                held_next  = '0;
                                bytes_next = '0;
                                mut_next   = '0;
                            end
                        end
                        lltc_pkg::ACT_INVALL:
                        begin
                            cmd.op     = lltc_pkg::TOP_FLUSH;
                            inval_next = inval_sum[32] ? lltc_pkg::ALL32 : inval_sum[31:0];
                            held_next  = '0;
                            bytes_next = '0;
                            mut_next   = '0;
                        end
                        lltc_pkg::ACT_TICK:
                            now_next = now_reg + 32'd1;
                        lltc_pkg::ACT_CLEAR:
                        begin
                            hits_next  = '0;
                            miss_next  = '0;
                            evict_next = '0;
                            inval_next = '0;
                        end
                        default:
                            status_next = lltc_pkg::ST_REJECT;
                    endcase
                end
            end

            S_CHECK:
            begin
                scan_cnt_next = '0;
                sel_have_next = 1'b0;
                state_next    = need_evict ? S_VICTIM : S_MATCH;
            end

            S_VICTIM:
            begin
                if (data_v_reg && better)
                begin
                    sel_have_next = 1'b1;
                    sel_idx_next  = data_idx_reg;
                    sel_rank_next = rd_rank;
                    sel_uses_next = rd_uses;
                    sel_cost_next = rd_ent.cost;
                end
                if (scan_end)
                    state_next = S_EVICT;
            end

            S_EVICT:
            begin
                cmd.op     = lltc_pkg::TOP_DROP;
                held_next  = held_reg - 1'b1;
                bytes_next = bytes_reg - HB_W'(sel_cost_reg);
                evict_next = lltc_pkg::sat_inc(evict_reg);
                state_next = S_CHECK;
            end

            S_MATCH:
            begin
                if (data_v_reg && hit_match)
                begin
                    sel_have_next    = 1'b1;
                    sel_idx_next     = data_idx_reg;
                    sel_rank_next    = rd_rank;
                    sel_uses_next    = rd_uses;
                    sel_created_next = rd_ent.created;
                    sel_cost_next    = rd_ent.cost;
                    state_next       = S_RESOLVE;
                end
                else if (scan_end)
                    state_next = S_RESOLVE;
            end

            S_RESOLVE:
            begin
                if (is_store_reg)
                begin
                    if (sel_have_reg)
                    begin
                        cmd.op     = lltc_pkg::TOP_DROP;
                        held_next  = held_reg - 1'b1;
                        bytes_next = bytes_reg - HB_W'(sel_cost_reg);
                    end
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_OUT;
                    if (sel_have_reg && cfg.ttl_limit != '0 &&
                        (now_reg - sel_created_reg) > cfg.ttl_limit)
                    begin
                        // expired: drop and count as a miss
                        cmd.op      = lltc_pkg::TOP_DROP;
                        held_next   = held_reg - 1'b1;
                        bytes_next  = bytes_reg - HB_W'(sel_cost_reg);
                        inval_next  = lltc_pkg::sat_inc(inval_reg);
                        miss_next   = lltc_pkg::sat_inc(miss_reg);
                        status_next = lltc_pkg::ST_MISS;
                    end
                    else if (sel_have_reg)
                    begin
                        cmd.op      = lltc_pkg::TOP_TOUCH;
                        cmd.uses    = lltc_pkg::sat_inc(sel_uses_reg);
                        hits_next   = lltc_pkg::sat_inc(hits_reg);
                        status_next = lltc_pkg::ST_HIT;
                        slot_next   = sel_idx_reg;
                    end
                    else
                    begin
                        miss_next   = lltc_pkg::sat_inc(miss_reg);
                        status_next = lltc_pkg::ST_MISS;
                    end
                end
            end

            S_INSERT:
            begin
                state_next = S_OUT;
                cmd_idx    = free_idx;
                if (free_have)
                begin
                    cmd.op      = lltc_pkg::TOP_INSERT;
                    held_next   = held_reg + 1'b1;
                    bytes_next  = bytes_reg + HB_W'(req_reg.cost);
                    status_next = lltc_pkg::ST_STORED;
                    slot_next   = free_idx;
                end
                else
                    status_next = lltc_pkg::ST_REJECT;
            end

            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            hits_reg     <= '0;
            miss_reg     <= '0;
            evict_reg    <= '0;
            inval_reg    <= '0;
            now_reg      <= '0;
            mut_reg      <= '0;
            held_reg     <= '0;
            bytes_reg    <= '0;
            scan_cnt_reg <= '0;
            data_v_reg   <= 1'b0;
            sel_have_reg <= 1'b0;
            is_store_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hits_reg     <= hits_next;
            miss_reg     <= miss_next;
            evict_reg    <= evict_next;
            inval_reg    <= inval_next;
            now_reg      <= now_next;
            mut_reg      <= mut_next;
            held_reg     <= held_next;
            bytes_reg    <= bytes_next;
            scan_cnt_reg <= scan_cnt_next;
            data_v_reg   <= issue;
            sel_have_reg <= sel_have_next;
            is_store_reg <= is_store_next;
        end
    end

    always_ff @(posedge clk) begin
        req_reg         <= req_next;
        status_reg      <= status_next;
        slot_reg        <= slot_next;
        data_idx_reg    <= scan_cnt_reg[IDX_W-1:0];
        sel_idx_reg     <= sel_idx_next;
        sel_rank_reg    <= sel_rank_next;
        sel_uses_reg    <= sel_uses_next;
        sel_created_reg <= sel_created_next;
        sel_cost_reg    <= sel_cost_next;
    end

endmodule

FILE: src/lltc_checker.sv
// Port-level checker for the result cache, bound to the top level
`include "lru_lfu_ttl_result_cache_assert.svh"

module lltc_checker #(
    parameter int ENTRIES = lltc_pkg::ENTRIES_DEF,
    localparam int IDX_W  = $clog2(ENTRIES),
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [2:0]       status,
    input logic [IDX_W-1:0] slot,
    input logic [31:0]      hit_count,
    input logic [CNT_W-1:0] entry_count
);

    `LLTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(slot), "result changed while stalled")
    `LLTC_ASSERT_NOW(a_one_request, clk, rst_n, in_ready, !out_valid,
        "ready for a request while a result is pending")
    `LLTC_ASSERT_NOW(a_entry_bound, clk, rst_n, out_valid, entry_count <= CNT_W'(ENTRIES),
        "entry count above table size")
    `LLTC_ASSERT_NOW(a_hit_counted, clk, rst_n, out_valid && status == lltc_pkg::ST_HIT,
        hit_count != '0, "hit reported with zero hit count")

endmodule

bind lru_lfu_ttl_result_cache lltc_checker #(.ENTRIES(ENTRIES)) u_lltc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot        (slot),
    .hit_count   (hit_count),
    .entry_count (entry_count)
);
